// ===== hdl/srjb_pkg.sv =====
// shared types, constants and helpers for the sequence reorder jitter buffer
`default_nettype none

package srjb_pkg;

  // number of descriptor cells in the row
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned HDL_W    = 16;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned LATE_W   = 7;
  localparam int unsigned STAT_W   = 3;

  localparam logic [LATE_W-1:0] MAX_LATE_RESET = 7'd32;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_LATE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_POPPED   = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [HDL_W-1:0] hdl_t;
  typedef logic [LEN_W-1:0] len_t;

  // search token that walks down the cell row, one cell per cycle
  typedef struct packed {
    logic go;
    seq_t want;
    seq_t expd;
    logic match_found;
    idx_t match_idx;
    hdl_t match_handle;
    len_t match_length;
    logic free_found;
    idx_t free_idx;
    logic best_found;
    idx_t best_idx;
    seq_t best_dist;
    seq_t best_seq;
    hdl_t best_handle;
    len_t best_length;
  } scan_t;

  // update broadcast from the controller to every cell
  typedef struct packed {
    logic wr_en;
    logic clr_en;
    idx_t idx;
    seq_t seq;
    hdl_t handle;
    len_t length;
  } cmd_t;

  // a comes before b in wrapping sequence order
  function automatic logic seq_precedes(input seq_t a, input seq_t b);
    seq_t diff;
    diff = a - b;
    return diff[SEQ_W-1];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sequence_reorder_jitter_buffer.sv =====
// top level: register port, request sequencer and the row of descriptor cells
//
// Reorders packet descriptors by 16-bit wrapping sequence number.
// Request channel: start/busy command style; a request is taken at a clock
// edge with start high and busy low. req_type_i selects push (0) or pop (1);
// seq_num_i, payload_handle_i and payload_length_i describe a pushed packet.
// Result channel: exactly one result per request, shown for one cycle with
// done_o high; the receiver cannot hold it off.
// Request flow: every request walks a search token through the row of
// CAPACITY cells, one cell per cycle, so done_o rises once the token has
// left the row and busy drops in the same cycle; a new request can be
// taken at the edge that ends the done_o cycle, so the block takes no new
// request before it is through with the last. The length of the cell row
// sets how long each request takes.
// Register port: APB-style, one register max_late at byte address 0; the
// user must write it only while busy is low, the block does not enforce it.
// Reset: all slots empty, not started, expected sequence and lost count zero,
// max_late back to 32. Slot contents need no clearing.
`default_nettype none

module sequence_reorder_jitter_buffer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         req_type_i,
  input  wire logic [15:0]                  seq_num_i,
  input  wire logic [15:0]                  payload_handle_i,
  input  wire logic [11:0]                  payload_length_i,
  output logic                              done_o,
  output logic [2:0]                        status_o,
  output logic [15:0]                       out_seq_o,
  output logic [15:0]                       out_handle_o,
  output logic [11:0]                       out_length_o,
  output logic                              skipped_o,
  output logic [15:0]                       lost_total_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [srjb_pkg::LATE_W-1:0] max_late_q;
  srjb_pkg::scan_t             chain [srjb_pkg::CAPACITY+1];
  srjb_pkg::cmd_t              cmd;
  logic                        reg_sel;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {{(32 - srjb_pkg::LATE_W){1'b0}}, max_late_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_late_q <= srjb_pkg::MAX_LATE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_late_q <= pwdata[srjb_pkg::LATE_W-1:0];
    end
  end

  // request sequencer
  srjb_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .seq_num_i        (seq_num_i),
    .payload_handle_i (payload_handle_i),
    .payload_length_i (payload_length_i),
    .max_late_i       (max_late_q),
    .scan_o           (chain[0]),
    .scan_i           (chain[srjb_pkg::CAPACITY]),
    .cmd_o            (cmd),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_seq_o        (out_seq_o),
    .out_handle_o     (out_handle_o),
    .out_length_o     (out_length_o),
    .skipped_o        (skipped_o),
    .lost_total_o     (lost_total_o)
  );

  // row of descriptor cells
  for (genvar g = 0; g < srjb_pkg::CAPACITY; g++) begin : g_cell
    srjb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (srjb_pkg::idx_t'(g)),
      .scan_i     (chain[g]),
      .cmd_i      (cmd),
      .scan_o     (chain[g+1])
    );
  end

endmodule

`default_nettype wire

// ===== hdl/srjb_cell.sv =====
// one descriptor slot plus one stage of the search token row
`default_nettype none

module srjb_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire srjb_pkg::idx_t  cell_idx_i,
  input  wire srjb_pkg::scan_t scan_i,
  input  wire srjb_pkg::cmd_t  cmd_i,
  output srjb_pkg::scan_t      scan_o
);

  logic            valid_q;
  srjb_pkg::seq_t  seq_q;
  srjb_pkg::hdl_t  handle_q;
  srjb_pkg::len_t  length_q;
  srjb_pkg::scan_t scan_d;
  srjb_pkg::scan_t scan_q;
  logic            go_q;
  srjb_pkg::seq_t  fwd_dist;
  logic            hit;
  logic            sel;

  // merge this slot into the passing token
  always_comb begin
    scan_d   = scan_i;
    fwd_dist = seq_q - scan_i.expd;
    hit      = valid_q && (seq_q == scan_i.want);
    if (hit && !scan_i.match_found) begin
      scan_d.match_found  = 1'b1;
      scan_d.match_idx    = cell_idx_i;
      scan_d.match_handle = handle_q;
      scan_d.match_length = length_q;
    end
    if (!valid_q && !scan_i.free_found) begin
      scan_d.free_found = 1'b1;
      scan_d.free_idx   = cell_idx_i;
    end
    if (valid_q && (!scan_i.best_found || (fwd_dist < scan_i.best_dist))) begin
      scan_d.best_found  = 1'b1;
      scan_d.best_idx    = cell_idx_i;
      scan_d.best_dist   = fwd_dist;
      scan_d.best_seq    = seq_q;
      scan_d.best_handle = handle_q;
      scan_d.best_length = length_q;
    end
  end

  assign sel = (cmd_i.idx == cell_idx_i);

  // slot occupancy and token strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      go_q    <= 1'b0;
    end else begin
      go_q <= scan_i.go;
      if (cmd_i.wr_en && sel) begin
        valid_q <= 1'b1;
      end else if (cmd_i.clr_en && sel) begin
        valid_q <= 1'b0;
      end
    end
  end

  // slot contents and token payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && sel) begin
      seq_q    <= cmd_i.seq;
      handle_q <= cmd_i.handle;
      length_q <= cmd_i.length;
    end
    scan_q <= scan_d;
  end

  // token strobe comes from the reset register
  always_comb begin
    scan_o    = scan_q;
    scan_o.go = go_q;
  end

endmodule

`default_nettype wire

// ===== hdl/srjb_ctrl.sv =====
// request sequencer: launches the search token, decides and commits the outcome
`default_nettype none

module srjb_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            req_type_i,
  input  wire srjb_pkg::seq_t                  seq_num_i,
  input  wire srjb_pkg::hdl_t                  payload_handle_i,
  input  wire srjb_pkg::len_t                  payload_length_i,
  input  wire logic [srjb_pkg::LATE_W-1:0]     max_late_i,
  output srjb_pkg::scan_t                      scan_o,
  input  wire srjb_pkg::scan_t                 scan_i,
  output srjb_pkg::cmd_t                       cmd_o,
  output logic                                 done_o,
  output logic [srjb_pkg::STAT_W-1:0]          status_o,
  output srjb_pkg::seq_t                       out_seq_o,
  output srjb_pkg::hdl_t                       out_handle_o,
  output srjb_pkg::len_t                       out_length_o,
  output logic                                 skipped_o,
  output srjb_pkg::seq_t                       lost_total_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                        state_q, state_d;
  logic                          inj_q, inj_d;
  logic                          started_q, started_d;
  srjb_pkg::seq_t                expected_q, expected_d;
  srjb_pkg::seq_t                lost_q, lost_d;
  srjb_pkg::cnt_t                held_q, held_d;
  logic                          pop_q;
  logic                          late_q;
  srjb_pkg::seq_t                seq_q;
  srjb_pkg::hdl_t                handle_q;
  srjb_pkg::len_t                length_q;
  logic                          done_d;
  logic [srjb_pkg::STAT_W-1:0]   status_d;
  srjb_pkg::seq_t                oseq_d;
  srjb_pkg::hdl_t                ohdl_d;
  srjb_pkg::len_t                olen_d;
  logic                          skip_d;
  logic                          accept;
  srjb_pkg::seq_t                exp_now;
  logic                          late_now;
  logic                          over_late;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_SCAN);

  // first push latches the expected sequence
  assign exp_now  = (!started_q && (req_type_i == srjb_pkg::REQ_PUSH)) ? seq_num_i
                                                                        : expected_q;
  assign late_now = srjb_pkg::seq_precedes(seq_num_i, exp_now);
  assign over_late = (32'(held_q) >= 32'(max_late_i));

  // token injected at the head of the row
  always_comb begin
    scan_o      = '0;
    scan_o.go   = inj_q;
    scan_o.want = pop_q ? expected_q : seq_q;
    scan_o.expd = expected_q;
  end

  // outcome of the search once the token leaves the row
  always_comb begin
    state_d    = state_q;
    inj_d      = 1'b0;
    started_d  = started_q;
    expected_d = expected_q;
    lost_d     = lost_q;
    held_d     = held_q;
    done_d     = 1'b0;
    status_d   = srjb_pkg::ST_NOTHING;
    oseq_d     = '0;
    ohdl_d     = '0;
    olen_d     = '0;
    skip_d     = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          inj_d   = 1'b1;
          if (req_type_i == srjb_pkg::REQ_PUSH) begin
            started_d  = 1'b1;
            expected_d = exp_now;
          end
        end
      end
      ST_SCAN: begin
        if (scan_i.go) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (!pop_q) begin
            if (late_q) begin
              status_d = srjb_pkg::ST_LATE;
            end else if (scan_i.match_found) begin
              status_d = srjb_pkg::ST_DUP;
            end else if (!scan_i.free_found) begin
              status_d = srjb_pkg::ST_FULL;
            end else begin
              status_d     = srjb_pkg::ST_STORED;
              held_d       = held_q + srjb_pkg::cnt_t'(1);
              cmd_o.wr_en  = 1'b1;
              cmd_o.idx    = scan_i.free_idx;
              cmd_o.seq    = seq_q;
              cmd_o.handle = handle_q;
              cmd_o.length = length_q;
            end
          end else if (held_q != '0) begin
            if (scan_i.match_found) begin
              status_d     = srjb_pkg::ST_POPPED;
              oseq_d       = expected_q;
              ohdl_d       = scan_i.match_handle;
              olen_d       = scan_i.match_length;
              held_d       = held_q - srjb_pkg::cnt_t'(1);
              expected_d   = expected_q + srjb_pkg::seq_t'(1);
              cmd_o.clr_en = 1'b1;
              cmd_o.idx    = scan_i.match_idx;
            end else if (over_late && scan_i.best_found) begin
              status_d     = srjb_pkg::ST_POPPED;
              oseq_d       = scan_i.best_seq;
              ohdl_d       = scan_i.best_handle;
              olen_d       = scan_i.best_length;
              skip_d       = 1'b1;
              lost_d       = lost_q + scan_i.best_dist;
              held_d       = held_q - srjb_pkg::cnt_t'(1);
              expected_d   = scan_i.best_seq + srjb_pkg::seq_t'(1);
              cmd_o.clr_en = 1'b1;
              cmd_o.idx    = scan_i.best_idx;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      inj_q      <= 1'b0;
      started_q  <= 1'b0;
      expected_q <= '0;
      lost_q     <= '0;
      held_q     <= '0;
      done_o     <= 1'b0;
    end else begin
      state_q    <= state_d;
      inj_q      <= inj_d;
      started_q  <= started_d;
      expected_q <= expected_d;
      lost_q     <= lost_d;
      held_q     <= held_d;
      done_o     <= done_d;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q    <= req_type_i;
      late_q   <= late_now;
      seq_q    <= seq_num_i;
      handle_q <= payload_handle_i;
      length_q <= payload_length_i;
    end
    if (done_d) begin
      status_o     <= status_d;
      out_seq_o    <= oseq_d;
      out_handle_o <= ohdl_d;
      out_length_o <= olen_d;
      skipped_o    <= skip_d;
      lost_total_o <= lost_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srjb_checker.sv =====
// port-level checks for the jitter buffer, bound to the top level
`default_nettype none

module srjb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [2:0]  status_o,
  input wire logic [15:0] out_seq_o,
  input wire logic [15:0] out_handle_o,
  input wire logic [11:0] out_length_o,
  input wire logic        skipped_o
);

  // a taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer not followed by busy");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in flight");

  // results never come in adjacent cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in a row");

  // packet fields are zero unless a packet was popped
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != srjb_pkg::ST_POPPED)) |->
      ((out_seq_o == 16'd0) && (out_handle_o == 16'd0) && (out_length_o == 12'd0)
       && !skipped_o))
    else $error("packet fields set without a pop");

endmodule

bind sequence_reorder_jitter_buffer srjb_checker u_srjb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .out_seq_o    (out_seq_o),
  .out_handle_o (out_handle_o),
  .out_length_o (out_length_o),
  .skipped_o    (skipped_o)
);

`default_nettype wire
